FILE: sv/afre_pkg.sv
// Shared types, constants and helpers for the air fuel ratio estimator.
`default_nettype none
package afre_pkg;
    localparam int WINDOW_LEN_DEF = 16;

    localparam logic [1:0] MIX_NORMAL = 2'd0;
    localparam logic [1:0] MIX_LEAN   = 2'd1;
    localparam logic [1:0] MIX_RICH   = 2'd2;

    localparam logic [1:0] REG_STOICH = 2'd0;
    localparam logic [1:0] REG_LAMBDA = 2'd1;
    localparam logic [1:0] REG_LEAN   = 2'd2;
    localparam logic [1:0] REG_RICH   = 2'd3;

    typedef struct packed {
        logic [10:0]       oxygen_millivolts;
        logic [7:0]        manifold_kpa;
        logic [13:0]       engine_speed;
        logic [6:0]        throttle_percent;
        logic signed [7:0] short_trim;
        logic signed [7:0] long_trim;
    } afre_in_t;

    typedef struct packed {
        logic [11:0] ratio_hundredths;
        logic [11:0] lambda_thousandths;
        logic [1:0]  mixture_state;
        logic [6:0]  stability_percent;
    } afre_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture item, form trimmed blend
        logic div_start; // form ratio, store it, start lambda division
        logic acc_start; // clear window sums
        logic acc_step;  // add one window entry
        logic sqrt_start;
        logic finish;    // form result
    } afre_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic acc_last;
    } afre_sts_t;

    // Oxygen sensor curve in hundredths of AFR.
    function automatic logic [10:0] oxy_curve(input logic [10:0] m, input logic [10:0] st);
        logic [10:0] d;
        logic [12:0] p;
        logic [10:0] r;
        d = 11'd0;
        p = 13'd0;
        r = 11'd1200;
        if (m < 11'd10) r = st;
        else if (m < 11'd100) r = 11'd1700;
        else if (m < 11'd200) r = 11'd1800 - m;
        else if (m < 11'd350)
        begin
            d = 11'd350 - m;
            r = 11'd1550 + 11'((19'(d) * 19'd171) >> 9);
        end
        else if (m < 11'd450)
        begin
            p = {2'b0, 11'd450 - m} << 2;
            r = 11'd1470 + 11'((21'(p) * 21'd205) >> 10);
        end
        else if (m < 11'd550)
        begin
            p = {2'b0, m - 11'd450} << 2;
            r = 11'd1470 - 11'((21'(p) * 21'd205) >> 10);
        end
        else if (m < 11'd700)
        begin
            d = m - 11'd550;
            r = 11'd1380 - 11'((19'(d) * 19'd171) >> 9);
        end
        else if (m < 11'd900) r = 11'd1300 - ((m - 11'd700) >> 1);
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: sv/afre_ctrl.sv
// Sequencing controller for the air fuel ratio estimator.
`default_nettype none
module afre_ctrl
    import afre_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output afre_cmd_t cmd,
    input  wire afre_sts_t sts
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    assign out_valid = ov_reg;
    // a new item may enter while the previous result waits
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.acc_start = 1'b1;
                state_next    = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_step = 1'b1;
                if (sts.acc_last)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.div_done && sts.sqrt_done && !ov_next)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

FILE: sv/afre_dp.sv
// Datapath: ratio, lambda divider, window statistics and square root.
`default_nettype none
module afre_dp
    import afre_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire afre_in_t  in_item,
    input  wire afre_cmd_t cmd,
    output afre_sts_t  sts,
    output afre_out_t  out_item,
    input  wire logic [10:0] stoich_ratio,
    input  wire logic [10:0] lambda_divisor,
    input  wire logic [11:0] lean_limit,
    input  wire logic [11:0] rich_limit
);
    localparam int IW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int NW = $clog2(WINDOW_LEN + 1);
    localparam int SW = 12 + NW;          // sum width
    localparam int QW = 24 + NW;          // square sum width
    localparam int VW = QW + NW;          // N*Q - S*S width
    localparam int RW = (VW + 1) / 2;     // root width
    localparam int RSW = 2 * RW;
    localparam int LIM = 200 * WINDOW_LEN;
    localparam int LW = $clog2(LIM + 1);

    // window memory and slot
    logic [11:0]   win_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] vld_reg;
    logic [IW-1:0] slot_reg;
    logic          full_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [11:0]   rd_data_reg;
    logic          rd_ok_reg;
    logic          rd_vld_reg;

    // ratio stage
    logic [11:0] ratio_reg;
    logic [1:0]  mix_reg;

    logic [10:0]        curve;
    logic [10:0]        est;
    logic [14:0]        blend;
    logic signed [9:0]  tsum;
    logic signed [26:0] num;
    logic signed [26:0] num_reg;
    logic [11:0]        ratio_c;

    // trimmed blend from the item
    always_comb
    begin
        curve = oxy_curve(in_item.oxygen_millivolts, stoich_ratio);
        est   = (in_item.engine_speed < 14'd200) ? stoich_ratio : 11'd900;
        if (in_item.oxygen_millivolts > 11'd10)
            blend = 15'(curve) * 15'd7 + 15'(est) * 15'd3;
        else
            blend = 15'(est) * 15'd10;
        tsum = 10'sd200 + 10'(in_item.short_trim) + 10'(in_item.long_trim);
        num  = $signed({1'b0, 15'(blend)}) * tsum;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            num_reg <= num;
    end

    // clamp, then num/2000 as (num/16)/125 by reciprocal
    always_comb
    begin
        if (num_reg < 27'sd1600000)
            ratio_c = 12'd800;
        else if (num_reg > 27'sd4400000)
            ratio_c = 12'd2200;
        else
            ratio_c = 12'((37'(num_reg[22:4]) * 37'd134218) >> 24);
    end

    // restoring divider for ratio*1000 / divisor
    logic [21:0] dq_reg;
    logic [11:0] drem_reg;
    logic [4:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [12:0] dtry;
    assign dtry = {drem_reg, dq_reg[21]} - {2'b0, lambda_divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= 5'd22;
        end
        else if (dbusy_reg)
        begin
            dcnt_reg <= dcnt_reg - 5'd1;
            if (dcnt_reg == 5'd1)
                dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dq_reg   <= 22'(ratio_c) * 22'd1000;
            drem_reg <= '0;
        end
        else if (dbusy_reg)
        begin
            if (!dtry[12])
            begin
                drem_reg <= dtry[11:0];
                dq_reg   <= {dq_reg[20:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[10:0], dq_reg[21]};
                dq_reg   <= {dq_reg[20:0], 1'b0};
            end
        end
    end

    // window write and slot update once the ratio is formed
    logic [IW-1:0] slot_inc;
    assign slot_inc = (slot_reg == IW'(WINDOW_LEN - 1)) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            full_reg <= 1'b0;
            vld_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            slot_reg <= slot_inc;
            vld_reg[slot_reg] <= 1'b1;
            if (slot_inc == '0)
                full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            win_mem[slot_reg] <= ratio_c;
            ratio_reg <= ratio_c;
            if (ratio_c > lean_limit)
                mix_reg <= MIX_LEAN;
            else if (ratio_c < rich_limit)
                mix_reg <= MIX_RICH;
            else
                mix_reg <= MIX_NORMAL;
        end
        rd_data_reg <= win_mem[rd_idx_reg];
        rd_ok_reg   <= vld_reg[rd_idx_reg];
    end

    // sum and square sum: one entry per cycle, read registered
    logic [SW-1:0] s_reg;
    logic [QW-1:0] q_reg;
    logic [11:0]   entry;
    assign entry = rd_ok_reg ? rd_data_reg : 12'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (cmd.acc_start)
        begin
            rd_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (cmd.acc_step)
        begin
            rd_vld_reg <= 1'b1;
            if (rd_idx_reg != IW'(WINDOW_LEN - 1))
                rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    logic [NW-1:0] acnt_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.acc_start)
        begin
            s_reg    <= '0;
            q_reg    <= '0;
            acnt_reg <= '0;
        end
        else if (cmd.acc_step && rd_vld_reg)
        begin
            s_reg    <= s_reg + SW'(entry);
            q_reg    <= q_reg + QW'(entry) * QW'(entry);
            acnt_reg <= acnt_reg + 1'b1;
        end
    end
    assign sts.acc_last = rd_vld_reg && (acnt_reg == NW'(WINDOW_LEN - 1));

    // bit-pair square root of N*Q - S*S
    logic [VW-1:0]  rad_reg;
    logic [RW-1:0]  root_reg;
    logic [RW+1:0]  srem_reg;
    logic [$clog2(RW+1)-1:0] scnt_reg;
    logic           sbusy_reg;
    logic [RSW-1:0] rad_pad;
    logic [RW+1:0]  strial;
    logic [RW+1:0]  sshift;

    assign rad_pad = RSW'(VW'(q_reg) * VW'(WINDOW_LEN) - VW'(s_reg) * VW'(s_reg));
    assign sshift  = {srem_reg[RW-1:0], rad_reg[VW-1 -: 2]};
    assign strial  = sshift - {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbusy_reg <= 1'b0;
            scnt_reg  <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            sbusy_reg <= 1'b1;
            scnt_reg  <= ($clog2(RW+1))'(RW);
        end
        else if (sbusy_reg)
        begin
            scnt_reg <= scnt_reg - 1'b1;
            if (scnt_reg == 1)
                sbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            rad_reg  <= VW'(rad_pad << (RSW - VW));
            root_reg <= '0;
            srem_reg <= '0;
        end
        else if (sbusy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (!strial[RW+1])
            begin
                srem_reg <= strial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= sshift;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign sts.div_done  = !dbusy_reg && !cmd.div_start;
    assign sts.sqrt_done = !sbusy_reg && !cmd.sqrt_start;

    // result formation; (LIM - r)/(2N) on a narrow value
    logic [LW-1:0] diff;
    logic [6:0]    stab;
    logic [11:0]   lam;
    assign diff = LW'(LIM) - LW'(root_reg);
    always_comb
    begin
        if (!full_reg)
            stab = 7'd80;
        else if (RW'(root_reg) >= RW'(LIM))
            stab = 7'd0;
        else
            stab = 7'(diff / (2 * WINDOW_LEN));
        if (lambda_divisor == 11'd0 || dq_reg > 22'd4095)
            lam = 12'd4095;
        else
            lam = dq_reg[11:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_item.ratio_hundredths   <= ratio_reg;
            out_item.lambda_thousandths <= lam;
            out_item.mixture_state      <= mix_reg;
            out_item.stability_percent  <= stab;
        end
    end

    logic unused_ok;
    assign unused_ok = ^{in_item.manifold_kpa, in_item.throttle_percent};
endmodule
`default_nettype wire

FILE: sv/air_fuel_ratio_estimator_unit.sv
// Top level of the air fuel ratio estimator.
// One engine sample item in, one result item out. The trimmed blend is
// captured on acceptance and the ratio formed in the next cycle; the
// window sums are then gathered one entry per cycle, and a bit-pair square
// root runs one root bit per cycle; a lambda divider overlaps them. A
// finished result waits in an output register while the next item starts;
// a result still waiting when the next one is ready holds the block until
// it is taken. The root width RW is 17 at the default window of 16.
// Registers: 0x0 stoich_ratio, 0x4 lambda_divisor, 0x8 lean_limit,
// 0xC rich_limit. Write them only while the block is idle.
`default_nettype none
module air_fuel_ratio_estimator_unit
    import afre_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire afre_in_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output afre_out_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    afre_cmd_t cmd;
    afre_sts_t sts;

    logic [10:0] stoich_reg;
    logic [10:0] lamdiv_reg;
    logic [11:0] lean_reg;
    logic [11:0] rich_reg;

    assign pready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stoich_reg <= 11'd1470;
            lamdiv_reg <= 11'd1470;
            lean_reg   <= 12'd1500;
            rich_reg   <= 12'd1400;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_STOICH: stoich_reg <= pwdata[10:0];
                REG_LAMBDA: lamdiv_reg <= pwdata[10:0];
                REG_LEAN:   lean_reg   <= pwdata[11:0];
                REG_RICH:   rich_reg   <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_STOICH: prdata = {21'd0, stoich_reg};
            REG_LAMBDA: prdata = {21'd0, lamdiv_reg};
            REG_LEAN:   prdata = {20'd0, lean_reg};
            REG_RICH:   prdata = {20'd0, rich_reg};
            default:    prdata = 32'd0;
        endcase
    end

    afre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    afre_dp #(.WINDOW_LEN(WINDOW_LEN)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_item        (in_data),
        .cmd            (cmd),
        .sts            (sts),
        .out_item       (out_data),
        .stoich_ratio   (stoich_reg),
        .lambda_divisor (lamdiv_reg),
        .lean_limit     (lean_reg),
        .rich_limit     (rich_reg)
    );
endmodule
`default_nettype wire

FILE: sv/afre_checker.sv
// Port-level checker for the air fuel ratio estimator, bound to the top level.
`default_nettype none
module afre_checker
    import afre_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire afre_out_t out_data
);
    // an accepted item leaves the block not ready in the very next cycle
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("busy missing");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped");

    // results stay in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.ratio_hundredths >= 12'd800 &&
                       out_data.ratio_hundredths <= 12'd2200 &&
                       out_data.stability_percent <= 7'd100 &&
                       out_data.mixture_state != 2'd3))
        else $error("result out of range");
endmodule

bind air_fuel_ratio_estimator_unit afre_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
